[src/ppdl_pkg.sv]
package ppdl_pkg;

	localparam int POS_WIDTH_DEF = 16;
	localparam int DRIVE_CAP_DEF = 300;

	localparam int DRIVE_W = 16;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;

	localparam logic [15:0] PROP_GAIN_RST   = 16'd256;
	localparam logic [15:0] INTEG_GAIN_RST  = 16'd0;
	localparam logic [8:0]  DEAD_ZONE_RST   = 9'd20;
	localparam logic [14:0] HINGE_LIMIT_RST = 15'd1100;
	localparam logic [7:0]  ARRIVE_BAND_RST = 8'd10;

	typedef enum logic [2:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DEAD_ZONE   = 3'd2,
		REG_HINGE_LIMIT = 3'd3,
		REG_ARRIVE_BAND = 3'd4,
		REG_LIMIT_CHECK = 3'd5,
		REG_ZERO_BRAKE  = 3'd6
	} reg_idx_t;

endpackage

[src/ppdl_if.sv]
interface ppdl_in_if #(
	parameter int POS_WIDTH = ppdl_pkg::POS_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [POS_WIDTH-1:0] ref_position;
	logic signed [POS_WIDTH-1:0] measured_position;

	modport source (output valid, output ref_position, output measured_position, input ready);
	modport sink   (input valid, input ref_position, input measured_position, output ready);
endinterface

interface ppdl_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [ppdl_pkg::DRIVE_W-1:0]    drive;
	logic                                   brake;
	logic                                   at_target;

	modport source (output valid, output drive, output brake, output at_target, input ready);
	modport sink   (input valid, input drive, input brake, input at_target, output ready);
endinterface

[src/position_pi_drive_limiter.sv]
// Results pass the input register, stage 2 and the output register, in that order.
// Throughput: one transaction per cycle while out_ch.ready is high; each stage loads
// whenever the stage after it is empty or moving, so input is still taken while a
// result waits at the output, until all stages are full; multipliers sit in stage 2.
// Reset (arst_n low, asynchronous): all stages empty, previous error zero,
// configuration registers back to their default values.
module position_pi_drive_limiter #(
	parameter int POS_WIDTH = ppdl_pkg::POS_WIDTH_DEF,
	parameter int DRIVE_CAP = ppdl_pkg::DRIVE_CAP_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppdl_pkg::ADDR_W-1:0]   paddr,
	input  logic [ppdl_pkg::DATA_W-1:0]   pwdata,
	output logic [ppdl_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	ppdl_in_if.sink                       in_ch,
	ppdl_out_if.source                    out_ch
);

	// Error carries one bit of growth, error sum two.
	localparam int ERR_W  = POS_WIDTH + 1;
	localparam int ESUM_W = POS_WIDTH + 2;
	localparam int KP_W   = ERR_W + 16;
	localparam int KI_W   = ESUM_W + 16;
	localparam int SUM_W  = KI_W + 1;
	localparam int RAW_W  = SUM_W - 8;
	localparam int CMP_W  = 34;
	localparam int DW     = ppdl_pkg::DRIVE_W;

	// ---------------------------------------------------------------------
	// Configuration registers, APB write on the access phase.
	// ---------------------------------------------------------------------
	logic [15:0] prop_gain_q;
	logic [15:0] integ_gain_q;
	logic [8:0]  dead_zone_q;
	logic [14:0] hinge_limit_q;
	logic [7:0]  arrive_band_q;
	logic        limit_check_q;
	logic        zero_brake_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= ppdl_pkg::PROP_GAIN_RST;
			integ_gain_q  <= ppdl_pkg::INTEG_GAIN_RST;
			dead_zone_q   <= ppdl_pkg::DEAD_ZONE_RST;
			hinge_limit_q <= ppdl_pkg::HINGE_LIMIT_RST;
			arrive_band_q <= ppdl_pkg::ARRIVE_BAND_RST;
			limit_check_q <= 1'b1;
			zero_brake_q  <= 1'b1;
		end else if (cfg_wr) begin
			case (ppdl_pkg::reg_idx_t'(paddr[4:2]))
				ppdl_pkg::REG_PROP_GAIN:   prop_gain_q   <= pwdata[15:0];
				ppdl_pkg::REG_INTEG_GAIN:  integ_gain_q  <= pwdata[15:0];
				ppdl_pkg::REG_DEAD_ZONE:   dead_zone_q   <= pwdata[8:0];
				ppdl_pkg::REG_HINGE_LIMIT: hinge_limit_q <= pwdata[14:0];
				ppdl_pkg::REG_ARRIVE_BAND: arrive_band_q <= pwdata[7:0];
				ppdl_pkg::REG_LIMIT_CHECK: limit_check_q <= pwdata[0];
				ppdl_pkg::REG_ZERO_BRAKE:  zero_brake_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back; unused addresses return zero.
	always_comb begin
		prdata = '0;
		case (ppdl_pkg::reg_idx_t'(paddr[4:2]))
			ppdl_pkg::REG_PROP_GAIN:   prdata = {16'd0, prop_gain_q};
			ppdl_pkg::REG_INTEG_GAIN:  prdata = {16'd0, integ_gain_q};
			ppdl_pkg::REG_DEAD_ZONE:   prdata = {23'd0, dead_zone_q};
			ppdl_pkg::REG_HINGE_LIMIT: prdata = {17'd0, hinge_limit_q};
			ppdl_pkg::REG_ARRIVE_BAND: prdata = {24'd0, arrive_band_q};
			ppdl_pkg::REG_LIMIT_CHECK: prdata = {31'd0, limit_check_q};
			ppdl_pkg::REG_ZERO_BRAKE:  prdata = {31'd0, zero_brake_q};
			default:                   prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Stage enables: a stage loads when it is empty or its successor loads.
	// ---------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_q;
	logic en_s1, en_s2, en_q;

	assign en_q  = !valid_q || out_ch.ready;
	assign en_s2 = !valid_s2 || en_q;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_ch.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_ch.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_q)  valid_q  <= valid_s2;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: input register.
	// ---------------------------------------------------------------------
	logic signed [POS_WIDTH-1:0] ref_s1, meas_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && in_ch.valid) begin
			ref_s1  <= in_ch.ref_position;
			meas_s1 <= in_ch.measured_position;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: error, error sum with the previous error, both gain products.
	// ---------------------------------------------------------------------
	logic signed [ERR_W-1:0]     err_d;
	logic signed [ESUM_W-1:0]    esum_d;
	logic signed [KP_W-1:0]      kp_d;
	logic signed [KI_W-1:0]      ki_d;
	logic signed [ERR_W-1:0]     prev_err_q;
	logic signed [ERR_W-1:0]     err_s2;
	logic signed [POS_WIDTH-1:0] meas_s2;
	logic signed [KP_W-1:0]      kp_s2;
	logic signed [KI_W-1:0]      ki_s2;
	logic                        load_s2;

	assign load_s2 = en_s2 && valid_s1;
	assign err_d   = ERR_W'(ref_s1) - ERR_W'(meas_s1);
	assign esum_d  = ESUM_W'(prev_err_q) + ESUM_W'(err_d);
	assign kp_d    = KP_W'(err_d) * KP_W'($signed({1'b0, prop_gain_q}));
	assign ki_d    = KI_W'(esum_d) * KI_W'($signed({1'b0, integ_gain_q}));

	// Keep the error of the last item that entered stage 2; items stay in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (load_s2) begin
			prev_err_q <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			err_s2  <= err_d;
			meas_s2 <= meas_s1;
			kp_s2   <= kp_d;
			ki_s2   <= ki_d;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: sum, divide by 256 toward zero, then the decision ladder.
	// ---------------------------------------------------------------------
	logic signed [SUM_W-1:0] sum_d, adj_d;
	logic signed [RAW_W-1:0] raw_d;
	logic signed [ERR_W-1:0] band_d;
	logic signed [RAW_W-1:0] cap_d, dz_d;
	logic signed [DW-1:0]    drive_d, sat_d;
	logic                    arrive_d, hinge_d, below_d, brake_d;
	logic signed [DW-1:0]    drive_q;
	logic                    brake_q, at_target_q;

	assign sum_d  = SUM_W'(kp_s2) + SUM_W'(ki_s2);
	// Bias negative values by 255 so the arithmetic shift truncates toward zero.
	assign adj_d  = sum_d + $signed({{(SUM_W-8){1'b0}}, {8{sum_d[SUM_W-1]}}});
	assign raw_d  = adj_d[SUM_W-1:8];
	assign band_d = $signed(ERR_W'(arrive_band_q));
	assign cap_d  = $signed(RAW_W'(DRIVE_CAP));
	assign dz_d   = $signed(RAW_W'(dead_zone_q));

	assign arrive_d = (err_s2 <= band_d && err_s2 >= -band_d) ||
	                  (zero_brake_q && raw_d == '0);
	assign hinge_d  = limit_check_q && raw_d > RAW_W'(1) &&
	                  CMP_W'(meas_s2) >= $signed(CMP_W'(hinge_limit_q));
	assign below_d  = limit_check_q && raw_d < -RAW_W'(1) && meas_s2 <= POS_WIDTH'(0);
	assign brake_d  = arrive_d || hinge_d || below_d;

	// Braking drive saturates raw to the 16-bit range.
	always_comb begin
		if (raw_d > RAW_W'(32767)) begin
			sat_d = DW'(32767);
		end else if (raw_d < -RAW_W'(32768)) begin
			sat_d = -DW'(32768);
		end else begin
			sat_d = raw_d[DW-1:0];
		end
	end

	// Brake: sat_d; powered drive: positive cap, dead-zone lift, then negative cap.
	always_comb begin
		if (brake_d) begin
			drive_d = sat_d;
		end else if (raw_d > cap_d) begin
			drive_d = cap_d[DW-1:0];
		end else if (raw_d > RAW_W'(0) && raw_d < dz_d) begin
			drive_d = dz_d[DW-1:0];
		end else if (raw_d < RAW_W'(0) && raw_d > -dz_d) begin
			drive_d = -(dz_d[DW-1:0]);
		end else if (raw_d < -cap_d) begin
			drive_d = -(cap_d[DW-1:0]);
		end else begin
			drive_d = raw_d[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_q && valid_s2) begin
			drive_q     <= drive_d;
			brake_q     <= brake_d;
			at_target_q <= arrive_d;
		end
	end

	assign out_ch.valid     = valid_q;
	assign out_ch.drive     = drive_q;
	assign out_ch.brake     = brake_q;
	assign out_ch.at_target = at_target_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_target_brakes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && at_target_q |-> brake_q)
		else $error("at_target without brake");

	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !brake_q |->
			(drive_q <= cap_d || drive_q == dz_d[DW-1:0]) &&
			(drive_q >= -cap_d || drive_q == -(dz_d[DW-1:0])))
		else $error("powered drive outside cap and dead zone");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1 && valid_s2 && valid_q && !out_ch.ready)
		else $error("input stalled with a free stage");

	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load_s2 |=> $stable(prev_err_q))
		else $error("previous error changed without a new item");

endmodule
